// ----- rtl/sist_pkg.sv -----
// Request and status codes for the sorted integer set table.
// Shared definitions only; no dependencies.
package sist_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } t_status;

    localparam int unsigned POS_W    = 6;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned FIELD_KW = 32;

endpackage

// ----- rtl/sist_ram.sv -----
// Key table storage: one write port, one read port with registered data.
// Stand-alone; no package dependencies.
module sist_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sorted_integer_set_table_core.sv -----
// Sorted set of distinct signed keys: binary-search insert, lookup, remove, clear.
// Search: S steps (up to ceil(log2(count+1))), each a key table read and then a compare;
// insert then shifts the keys above the index upward; remove shifts the keys above pos down.
// Clear only resets the count. Shifts use the key table's single read port, one entry per read and write pair.
// One request in flight; a new one is taken while the previous result waits.
// Reset (synchronous, active low) empties the set; the table itself is not cleared.
module sorted_integer_set_table_core #(
    parameter int unsigned CAPACITY  = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_req_type,
    input  logic signed [sist_pkg::FIELD_KW-1:0] i_key,
    input  logic [sist_pkg::POS_W-1:0]           i_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_status,
    output logic                                 o_found,
    output logic [sist_pkg::POS_W-1:0]           o_index,
    output logic signed [sist_pkg::FIELD_KW-1:0] o_removed_key,
    output logic [sist_pkg::COUNT_W-1:0]         o_count
);
    import sist_pkg::*;

    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_CMP, S_SH_RD, S_SH_WR, S_INS_WR, S_RM_RD, S_RM_CAP, S_DONE
    } t_state;

    t_state               r_state;
    t_req                 r_req;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]     r_used, r_lo, r_hi, r_mid, r_ptr;
    logic                 r_eq, r_up;
    t_status              r_status;
    logic                 r_found;
    logic [CNT_W-1:0]     r_index;
    logic [KEY_WIDTH-1:0] r_removed;

    logic                 r_ovalid;
    t_status              r_ostatus;
    logic                 r_ofound;
    logic [POS_W-1:0]     r_oindex;
    logic [FIELD_KW-1:0]  r_oremoved;
    logic [COUNT_W-1:0]   r_ocount;

    logic                 in_xfer, out_free, sh_more, key_less;
    logic [CNT_W-1:0]     mid;
    logic [ADDR_W-1:0]    raddr, waddr;
    logic [KEY_WIDTH-1:0] wdata, rdata;
    logic                 we;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign key_less = $signed(rdata) < $signed(r_key);
    assign sh_more  = r_up ? (r_ptr > r_lo) : ((r_ptr + 1'b1) < r_used);

    // read address and write port, chosen by state
    always_comb begin
        raddr = r_ptr[ADDR_W-1:0];
        we    = 1'b0;
        waddr = r_ptr[ADDR_W-1:0];
        wdata = rdata;
        case (r_state)
            S_SRCH:  raddr = mid[ADDR_W-1:0];
            S_SH_RD: raddr = r_up ? ADDR_W'(r_ptr - 1'b1) : ADDR_W'(r_ptr + 1'b1);
            S_SH_WR: we = 1'b1;
            S_INS_WR: begin
                we    = 1'b1;
                waddr = r_lo[ADDR_W-1:0];
                wdata = r_key;
            end
            default: raddr = r_ptr[ADDR_W-1:0];
        endcase
    end

    sist_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_req     <= t_req'(i_req_type);
                        r_key     <= KEY_WIDTH'($unsigned(i_key));
                        r_found   <= 1'b0;
                        r_index   <= '0;
                        r_removed <= '0;
                        r_lo      <= '0;
                        r_hi      <= r_used;
                        r_eq      <= 1'b0;
                        r_up      <= 1'b0;
                        r_ptr     <= CNT_W'(i_position);
                        case (t_req'(i_req_type))
                            REQ_INSERT, REQ_LOOKUP: begin
                                r_status <= ST_DONE;
                                r_state  <= S_SRCH;
                            end
                            REQ_REMOVE: begin
                                if (CMP_W'(i_position) >= CMP_W'(r_used)) begin
                                    r_status <= ST_BAD_POS;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_state  <= S_RM_RD;
                                end
                            end
                            default: begin
                                r_status <= ST_DONE;
                                r_used   <= '0;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid;
                        r_state <= S_CMP;
                    end else if (r_eq) begin
                        r_found  <= 1'b1;
                        r_index  <= r_lo;
                        r_status <= (r_req == REQ_INSERT) ? ST_PRESENT : ST_DONE;
                        r_state  <= S_DONE;
                    end else if (r_req == REQ_LOOKUP) begin
                        r_index <= r_lo;
                        r_state <= S_DONE;
                    end else if (r_used >= CNT_W'(CAPACITY)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_index <= r_lo;
                        r_ptr   <= r_used;
                        r_up    <= 1'b1;
                        r_state <= S_SH_RD;
                    end
                end
                S_CMP: begin
                    // shared compare: narrow the search window
                    if (key_less) begin
                        r_lo <= r_mid + 1'b1;
                    end else begin
                        r_hi <= r_mid;
                        r_eq <= (rdata == r_key);
                    end
                    r_state <= S_SRCH;
                end
                S_SH_RD: begin
                    if (sh_more) begin
                        r_state <= S_SH_WR;
                    end else if (r_up) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_used  <= r_used - 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_SH_WR: begin
                    r_ptr   <= r_up ? (r_ptr - 1'b1) : (r_ptr + 1'b1);
                    r_state <= S_SH_RD;
                end
                S_INS_WR: begin
                    r_used  <= r_used + 1'b1;
                    r_state <= S_DONE;
                end
                S_RM_RD: r_state <= S_RM_CAP;
                S_RM_CAP: begin
                    r_removed <= rdata;
                    r_state   <= S_SH_RD;
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_ovalid   <= 1'b1;
                        r_ostatus  <= r_status;
                        r_ofound   <= r_found;
                        r_oindex   <= POS_W'(r_index);
                        r_oremoved <= FIELD_KW'(r_removed);
                        r_ocount   <= COUNT_W'(r_used);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_found       = r_ofound;
    assign o_index       = r_oindex;
    assign o_removed_key = r_oremoved;
    assign o_count       = r_ocount;

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo <= r_hi) && (r_hi <= r_used))
        else $error("search window out of order");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_WR) |-> (r_used < CNT_W'(CAPACITY)) && r_up)
        else $error("insert write into a full table");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> (r_ptr < CNT_W'(CAPACITY)) && (r_ptr <= r_used))
        else $error("shift write beyond the held keys");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> o_out_valid && (r_state == S_IDLE))
        else $error("finished result not presented");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_req_type == REQ_CLEAR) |=> (r_state == S_DONE) && (r_used == '0))
        else $error("clear did not empty the set");

endmodule
